@@ rtl/homophonic_cipher_codec_top_assert.svh @@
// assertion macros for the homophonic cipher codec checker
`ifndef HOMOPHONIC_CIPHER_CODEC_TOP_ASSERT_SVH
`define HOMOPHONIC_CIPHER_CODEC_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define HCC_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (c)) else $error("hcc check failed");

// next-cycle implication, off during reset
`define HCC_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (c)) else $error("hcc check failed");

// next-cycle implication, also checked across reset
`define HCC_RST(lbl, a, c) lbl: assert property (@(posedge clk) \
  (a) |=> (c)) else $error("hcc reset check failed");

`endif

@@ rtl/hcc_pkg.sv @@
// shared types and constants of the homophonic cipher codec
package hcc_pkg;

  localparam int NUM_LETTERS    = 26;
  localparam int MAX_DIGITS     = 8;
  localparam int MAX_HOMOPHONES = 8;
  localparam int OUT_LIMIT      = 16;

  localparam logic [1:0] OP_TEXT  = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_in;
    logic        end_of_text;
    logic [14:0] random_value;
    logic [4:0]  letter_index;
    logic [2:0]  slot_index;
    logic [31:0] entry_digits;
    logic [3:0]  entry_length;
    logic [3:0]  homophone_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_out;
  } out_item_t;

  // byte request from the sequencer to the output stage
  typedef struct packed {
    logic       push;
    logic       fin;
    logic [7:0] data;
  } emit_req_t;

endpackage

@@ rtl/hcc_ram.sv @@
// generic single-write, single-read ram with registered read data
module hcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/hcc_emit.sv @@
// output stage: holds one byte back so the last one of an item can be flagged
module hcc_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hcc_pkg::emit_req_t    em_req,
  output logic                  em_rdy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hcc_pkg::out_item_t    out_data
);
  import hcc_pkg::*;

  localparam int NW = $clog2(OUT_LIMIT + 1);

  logic          pend_v_r;
  logic [7:0]    pend_b_r;
  logic [NW-1:0] n_r;
  logic          out_v_r;
  out_item_t     out_r;

  assign em_rdy    = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      n_r      <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (em_rdy && em_req.push && (n_r < NW'(OUT_LIMIT))) begin
        if (pend_v_r) begin
          out_r   <= '{char_out: pend_b_r, last_out: 1'b0};
          out_v_r <= 1'b1;
        end
        pend_v_r <= 1'b1;
        pend_b_r <= em_req.data;
        n_r      <= n_r + NW'(1);
      end else if (em_rdy && em_req.fin) begin
        // item done: the held byte is the last one
        if (pend_v_r) begin
          out_r   <= '{char_out: pend_b_r, last_out: 1'b1};
          out_v_r <= 1'b1;
        end
        pend_v_r <= 1'b0;
        n_r      <= '0;
      end
    end
  end

endmodule

@@ rtl/hcc_ctrl.sv @@
// sequencer: table loads, modulo unit, table scan and byte parser
module hcc_ctrl #(
  parameter int MAX_D = hcc_pkg::MAX_DIGITS,
  parameter int MAX_H = hcc_pkg::MAX_HOMOPHONES,
  parameter int DW    = 4 * MAX_D,
  parameter int LW    = $clog2(MAX_D + 1),
  parameter int AW    = $clog2(hcc_pkg::NUM_LETTERS * MAX_H)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hcc_pkg::in_item_t    in_data,
  output hcc_pkg::emit_req_t   em_req,
  input  logic                 em_rdy,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [DW+LW-1:0]     ram_wdata,
  output logic                 ram_re,
  output logic [AW-1:0]        ram_raddr,
  input  logic [DW+LW-1:0]     ram_rdata
);
  import hcc_pkg::*;

  localparam int CW = $clog2(MAX_H + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_LBR   = 8'h7B;
  localparam logic [7:0] CH_RBR   = 8'h7D;
  localparam logic [7:0] CH_A     = 8'h61;

  typedef enum logic [3:0] {
    S_IDLE, S_ENC, S_MOD, S_EREAD, S_ELOAD, S_EDIG, S_SEQ,
    S_DEC, S_DFL, S_FIND, S_SCANA, S_SCANC, S_NF, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TOKEN, PH_DASH, PH_DASH1, PH_BRACE, PH_BRACED
  } phase_t;

  function automatic logic [7:0] nf_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h27;
      4'd4:    c = 8'h74;
      4'd5:    c = 8'h20;
      4'd6:    c = 8'h46;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h6E;
      4'd9:    c = 8'h64;
      default: c = 8'h21;
    endcase
    return c;
  endfunction

  function automatic logic [AW-1:0] tab_addr(input logic [4:0] l, input logic [CW-1:0] s);
    return AW'(AW'(l) * AW'(MAX_H) + AW'(s));
  endfunction

  state_t          st_r, st_nxt;
  phase_t          ph_r, ph_nxt;
  logic            mode_r, mode_nxt;
  logic [7:0]      b_r, b_nxt;
  logic            eot_r, eot_nxt;
  logic [14:0]     rnd_r, rnd_nxt;
  logic [DW-1:0]   tok_r, tok_nxt;
  logic [LW-1:0]   tlen_r, tlen_nxt;
  logic            tovf_r, tovf_nxt;
  logic [7:0]      held_r, held_nxt;
  logic            ffl_r, ffl_nxt;
  logic [4:0]      let_r, let_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [CW:0]     rem_r, rem_nxt;
  logic [3:0]      bit_r, bit_nxt;
  logic [LW-1:0]   k_r, k_nxt;
  logic [1:0]      sq_r, sq_nxt;
  logic            sqnl_r, sqnl_nxt;
  logic [3:0]      nf_r, nf_nxt;
  logic [CW-1:0]   cnt_r [NUM_LETTERS];

  logic            cw_en;
  logic [4:0]      cw_idx;
  logic [CW-1:0]   cw_val;

  logic            b_dig, b_let;
  logic [4:0]      b_letter;
  logic [CW-1:0]   cnt_b, cnt_l;
  logic [CW:0]     mod_t;
  logic [LW-1:0]   k_dec;
  logic [3:0]      nib;
  logic [63:0]     dig64;
  logic [DW-1:0]   wdig;
  logic [LW-1:0]   lsat;
  logic            match;
  state_t          end_st, fin_st;
  logic [7:0]      seq_b;

  assign in_ready = (st_r == S_IDLE);

  assign b_dig    = (b_r >= CH_ZERO) && (b_r <= 8'h39);
  assign b_let    = ((b_r >= 8'h41) && (b_r <= 8'h5A)) || ((b_r >= 8'h61) && (b_r <= 8'h7A));
  assign b_letter = 5'((b_r | 8'h20) - CH_A);
  assign cnt_b    = b_let ? cnt_r[b_letter] : '0;
  assign cnt_l    = (let_r < 5'(NUM_LETTERS)) ? cnt_r[let_r] : '0;
  assign mod_t    = {rem_r[CW-1:0], rnd_r[bit_r]};
  assign k_dec    = k_r - LW'(1);
  assign nib      = ram_rdata[{k_dec, 2'b00} +: 4];
  assign match    = (ram_rdata[DW+LW-1:DW] == tlen_r) && (ram_rdata[DW-1:0] == tok_r);
  assign end_st   = eot_r ? S_DFL : S_DONE;
  assign fin_st   = ffl_r ? S_DFL : ((b_r == CH_SPACE) ? end_st : S_DEC);
  assign dig64    = {32'b0, in_data.entry_digits};
  assign lsat     = (int'(in_data.entry_length) > MAX_D) ? LW'(MAX_D)
                                                          : LW'(in_data.entry_length);

  always_comb begin
    for (int n = 0; n < DW; n++) begin
      wdig[n] = dig64[n] && ((n / 4) < int'(lsat));
    end
  end

  always_comb begin
    case (sq_r)
      2'd0:    seq_b = sqnl_r ? CH_SPACE : CH_LBR;
      2'd1:    seq_b = sqnl_r ? CH_DASH : b_r;
      2'd2:    seq_b = sqnl_r ? CH_ONE : CH_RBR;
      default: seq_b = CH_NL;
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    mode_nxt = mode_r;
    b_nxt    = b_r;
    eot_nxt  = eot_r;
    rnd_nxt  = rnd_r;
    tok_nxt  = tok_r;
    tlen_nxt = tlen_r;
    tovf_nxt = tovf_r;
    held_nxt = held_r;
    ffl_nxt  = ffl_r;
    let_nxt  = let_r;
    j_nxt    = j_r;
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    k_nxt    = k_r;
    sq_nxt   = sq_r;
    sqnl_nxt = sqnl_r;
    nf_nxt   = nf_r;
    em_req   = '0;
    ram_we   = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re   = 1'b0;
    ram_raddr = '0;
    cw_en    = 1'b0;
    cw_idx   = in_data.letter_index;
    cw_val   = (int'(in_data.homophone_count) > MAX_H) ? CW'(MAX_H)
                                                        : CW'(in_data.homophone_count);

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            OP_ENTRY: begin
              if ((int'(in_data.letter_index) < NUM_LETTERS) &&
                  (int'(in_data.slot_index) < MAX_H)) begin
                ram_we    = 1'b1;
                ram_waddr = tab_addr(in_data.letter_index, CW'(in_data.slot_index));
                ram_wdata = {lsat, wdig};
              end
            end
            OP_COUNT: begin
              cw_en = (int'(in_data.letter_index) < NUM_LETTERS);
            end
            OP_TEXT: begin
              b_nxt   = in_data.char_in;
              eot_nxt = in_data.end_of_text;
              rnd_nxt = in_data.random_value;
              st_nxt  = mode_r ? S_DEC : S_ENC;
            end
            default: ;
          endcase
        end
        if (cfg_we) begin
          mode_nxt = cfg_wdata;
          ph_nxt   = PH_IDLE;
          tok_nxt  = '0;
          tlen_nxt = '0;
          tovf_nxt = 1'b0;
          held_nxt = '0;
        end
      end

      S_ENC: begin
        if (b_let && (cnt_b != '0)) begin
          let_nxt = b_letter;
          rem_nxt = '0;
          bit_nxt = 4'd14;
          st_nxt  = S_MOD;
        end else if (b_dig || (b_r == CH_NL)) begin
          sq_nxt   = 2'd0;
          sqnl_nxt = !b_dig;
          st_nxt   = S_SEQ;
        end else if (em_rdy) begin
          // zero-count letter gives the bare space
          em_req.push = 1'b1;
          em_req.data = b_let ? CH_SPACE : b_r;
          st_nxt      = S_DONE;
        end
      end

      // restoring remainder, one random bit per cycle
      S_MOD: begin
        rem_nxt = (mod_t >= {1'b0, cnt_l}) ? mod_t - {1'b0, cnt_l} : mod_t;
        bit_nxt = bit_r - 4'd1;
        if (bit_r == 4'd0) begin
          st_nxt = S_EREAD;
        end
      end

      S_EREAD: begin
        ram_re    = 1'b1;
        ram_raddr = tab_addr(let_r, rem_r[CW-1:0]);
        st_nxt    = S_ELOAD;
      end

      S_ELOAD: begin
        k_nxt  = ram_rdata[DW+LW-1:DW];
        st_nxt = S_EDIG;
      end

      S_EDIG: begin
        if (em_rdy) begin
          em_req.push = 1'b1;
          if (k_r == '0) begin
            em_req.data = CH_SPACE;
            st_nxt      = S_DONE;
          end else begin
            em_req.data = CH_ZERO + {4'd0, nib};
            k_nxt       = k_dec;
          end
        end
      end

      S_SEQ: begin
        if (em_rdy) begin
          em_req.push = 1'b1;
          em_req.data = seq_b;
          sq_nxt      = sq_r + 2'd1;
          if (sq_r == (sqnl_r ? 2'd3 : 2'd2)) begin
            st_nxt = S_DONE;
          end
        end
      end

      S_DEC: begin
        case (ph_r)
          PH_TOKEN: begin
            if (b_dig) begin
              if (tlen_r < LW'(MAX_D)) begin
                tok_nxt  = (tok_r << 4) | DW'(b_r[3:0]);
                tlen_nxt = tlen_r + LW'(1);
              end else begin
                tovf_nxt = 1'b1;
              end
              st_nxt = end_st;
            end else begin
              ffl_nxt = 1'b0;
              st_nxt  = S_FIND;
            end
          end
          PH_DASH: begin
            if (b_r == CH_ONE) begin
              ph_nxt = PH_DASH1;
              st_nxt = end_st;
            end else if (em_rdy) begin
              em_req.push = 1'b1;
              em_req.data = CH_DASH;
              ph_nxt      = PH_IDLE;
            end
          end
          PH_DASH1: begin
            if (em_rdy) begin
              em_req.push = 1'b1;
              if (b_r == CH_NL) begin
                em_req.data = CH_NL;
                ph_nxt      = PH_IDLE;
                st_nxt      = end_st;
              end else begin
                // the dash was literal, the one starts a token
                em_req.data = CH_DASH;
                tok_nxt     = DW'(4'd1);
                tlen_nxt    = LW'(1);
                tovf_nxt    = 1'b0;
                ph_nxt      = PH_TOKEN;
              end
            end
          end
          PH_BRACE: begin
            if (b_dig) begin
              held_nxt = b_r;
              ph_nxt   = PH_BRACED;
              st_nxt   = end_st;
            end else if (em_rdy) begin
              em_req.push = 1'b1;
              em_req.data = CH_LBR;
              ph_nxt      = PH_IDLE;
            end
          end
          PH_BRACED: begin
            if (em_rdy) begin
              em_req.push = 1'b1;
              if (b_r == CH_RBR) begin
                em_req.data = held_r;
                ph_nxt      = PH_IDLE;
                st_nxt      = end_st;
              end else begin
                em_req.data = CH_LBR;
                tok_nxt     = DW'(held_r[3:0]);
                tlen_nxt    = LW'(1);
                tovf_nxt    = 1'b0;
                ph_nxt      = PH_TOKEN;
              end
            end
          end
          default: begin
            if (b_dig) begin
              tok_nxt  = DW'(b_r[3:0]);
              tlen_nxt = LW'(1);
              tovf_nxt = 1'b0;
              ph_nxt   = PH_TOKEN;
              st_nxt   = end_st;
            end else if (b_r == CH_DASH) begin
              ph_nxt = PH_DASH;
              st_nxt = end_st;
            end else if (b_r == CH_LBR) begin
              ph_nxt = PH_BRACE;
              st_nxt = end_st;
            end else if (em_rdy) begin
              em_req.push = 1'b1;
              em_req.data = b_r;
              ph_nxt      = PH_IDLE;
              st_nxt      = end_st;
            end
          end
        endcase
      end

      // end of text: drain whatever the parser still holds
      S_DFL: begin
        case (ph_r)
          PH_TOKEN: begin
            ffl_nxt = 1'b1;
            st_nxt  = S_FIND;
          end
          PH_DASH, PH_BRACE: begin
            if (em_rdy) begin
              em_req.push = 1'b1;
              em_req.data = (ph_r == PH_DASH) ? CH_DASH : CH_LBR;
              ph_nxt      = PH_IDLE;
            end
          end
          PH_DASH1, PH_BRACED: begin
            if (em_rdy) begin
              em_req.push = 1'b1;
              em_req.data = (ph_r == PH_DASH1) ? CH_DASH : CH_LBR;
              tok_nxt     = (ph_r == PH_DASH1) ? DW'(4'd1) : DW'(held_r[3:0]);
              tlen_nxt    = LW'(1);
              tovf_nxt    = 1'b0;
              ph_nxt      = PH_TOKEN;
            end
          end
          default: st_nxt = S_DONE;
        endcase
      end

      S_FIND: begin
        let_nxt = '0;
        j_nxt   = '0;
        nf_nxt  = '0;
        st_nxt  = tovf_r ? S_NF : S_SCANA;
      end

      // walk letters in order, then slots inside the count
      S_SCANA: begin
        if (let_r == 5'(NUM_LETTERS)) begin
          st_nxt = S_NF;
        end else if (j_r >= cnt_l) begin
          let_nxt = let_r + 5'd1;
          j_nxt   = '0;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = tab_addr(let_r, j_r);
          st_nxt    = S_SCANC;
        end
      end

      S_SCANC: begin
        if (!match) begin
          j_nxt  = j_r + CW'(1);
          st_nxt = S_SCANA;
        end else if (em_rdy) begin
          em_req.push = 1'b1;
          em_req.data = CH_A + {3'd0, let_r};
          tok_nxt     = '0;
          tlen_nxt    = '0;
          tovf_nxt    = 1'b0;
          ph_nxt      = PH_IDLE;
          st_nxt      = fin_st;
        end
      end

      S_NF: begin
        if (em_rdy) begin
          em_req.push = 1'b1;
          em_req.data = nf_char(nf_r);
          nf_nxt      = nf_r + 4'd1;
          if (nf_r == 4'd10) begin
            tok_nxt  = '0;
            tlen_nxt = '0;
            tovf_nxt = 1'b0;
            ph_nxt   = PH_IDLE;
            st_nxt   = fin_st;
          end
        end
      end

      S_DONE: begin
        em_req.fin = 1'b1;
        if (em_rdy) begin
          st_nxt = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ph_r   <= PH_IDLE;
      mode_r <= 1'b0;
      tok_r  <= '0;
      tlen_r <= '0;
      tovf_r <= 1'b0;
      held_r <= '0;
      for (int i = 0; i < NUM_LETTERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      mode_r <= mode_nxt;
      tok_r  <= tok_nxt;
      tlen_r <= tlen_nxt;
      tovf_r <= tovf_nxt;
      held_r <= held_nxt;
      if (cw_en) begin
        cnt_r[cw_idx] <= cw_val;
      end
    end
    b_r    <= b_nxt;
    eot_r  <= eot_nxt;
    rnd_r  <= rnd_nxt;
    ffl_r  <= ffl_nxt;
    let_r  <= let_nxt;
    j_r    <= j_nxt;
    rem_r  <= rem_nxt;
    bit_r  <= bit_nxt;
    k_r    <= k_nxt;
    sq_r   <= sq_nxt;
    sqnl_r <= sqnl_nxt;
    nf_r   <= nf_nxt;
  end

endmodule

@@ rtl/homophonic_cipher_codec_top.sv @@
// top level of the homophonic substitution cipher codec
//
//   port group  direction  handshake        payload
//   in_         input      in_valid/ready   in_item_t
//   out_        output     out_valid/ready  out_item_t, one byte per transfer
//   cfg_        input      cfg_we           cfg_wdata (decrypt mode)
//
// a table load is taken while in_ready is high; a text byte holds in_ready
// low until its bytes have all been handed to the output stage.
// encrypting a letter: a decode step, the remainder unit, the table read,
// then the output bytes and the close of the item.
// decrypting a token: a scan of each letter's stored homophones through the
// one ram read port, then the output bytes.
// a byte that waits on out_ready holds the sequencer.
// rst_n is synchronous; letter counts and parser clear at once, the table
// itself is not cleared.
module homophonic_cipher_codec_top #(
  parameter int MAX_DIGITS     = hcc_pkg::MAX_DIGITS,
  parameter int MAX_HOMOPHONES = hcc_pkg::MAX_HOMOPHONES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcc_pkg::out_item_t  out_data
);
  import hcc_pkg::*;

  localparam int DW    = 4 * MAX_DIGITS;
  localparam int LW    = $clog2(MAX_DIGITS + 1);
  localparam int DEPTH = NUM_LETTERS * MAX_HOMOPHONES;
  localparam int AW    = $clog2(DEPTH);

  emit_req_t         em_req;
  logic              em_rdy;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DW+LW-1:0]  ram_wdata, ram_rdata;

  hcc_ctrl #(
    .MAX_D (MAX_DIGITS),
    .MAX_H (MAX_HOMOPHONES),
    .DW    (DW),
    .LW    (LW),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .em_req    (em_req),
    .em_rdy    (em_rdy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // digits and length of every homophone
  hcc_ram #(
    .WIDTH (DW + LW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hcc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .em_req    (em_req),
    .em_rdy    (em_rdy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/hcc_checker.sv @@
// port-level checks of the codec, bound to the top level
`include "homophonic_cipher_codec_top_assert.svh"

module hcc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input hcc_pkg::in_item_t   in_data,
  input logic                out_valid,
  input logic                out_ready,
  input hcc_pkg::out_item_t  out_data
);
  import hcc_pkg::*;

  // a stalled result holds
  `HCC_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // output register empty right after reset
  `HCC_RST(a_rst_empty, !rst_n, !out_valid)
  // a text byte leaves the block busy right after it is taken
  `HCC_NEXT(a_text_busy, in_valid && in_ready && (in_data.opcode == OP_TEXT), !in_ready)
  // while taking input, only a finished item's last byte can be waiting
  `HCC_IMPL(a_ready_last, in_ready && out_valid, out_data.last_out)

endmodule

bind homophonic_cipher_codec_top hcc_checker u_hcc_checker (.*);
